// File: design/mca_pkg.sv
package mca_pkg;

  localparam int COST_W = 16;
  localparam int IDX_W  = 4;
  localparam logic [COST_W-1:0] COST_IMPOSSIBLE = 16'hFFFF;

  // last matrix entry as seen by the solver
  typedef struct packed {
    logic              go;
    logic [IDX_W-1:0]  last_row;
    logic [IDX_W-1:0]  last_col;
    logic [COST_W-1:0] thr;
  } mca_start_t;

  // one result request from the solver
  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [COST_W-1:0] cost;
    logic              is_match;
    logic              last;
  } mca_res_t;

endpackage

// File: design/mca_in_if.sv
interface mca_in_if;
  import mca_pkg::*;

  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;
  logic [IDX_W-1:0]  row_index;
  logic [IDX_W-1:0]  col_index;
  logic [COST_W-1:0] cost_limit;
  logic              last_entry;

  modport source (output valid, cost, row_index, col_index, cost_limit, last_entry,
                  input ready);
  modport sink   (input valid, cost, row_index, col_index, cost_limit, last_entry,
                  output ready);
endinterface

// File: design/mca_out_if.sv
interface mca_out_if;
  import mca_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  match_row;
  logic [IDX_W-1:0]  match_col;
  logic [COST_W-1:0] match_cost;
  logic              is_match;
  logic              last_result;

  modport source (output valid, match_row, match_col, match_cost, is_match, last_result,
                  input ready);
  modport sink   (input valid, match_row, match_col, match_cost, is_match, last_result,
                  output ready);
endinterface

// File: design/mca_store.sv
module mca_store #(
  parameter int MAX_DIM = 16,
  localparam int SAW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [SAW-1:0]             waddr,
  input  logic [mca_pkg::COST_W-1:0] wdata,
  input  logic [SAW-1:0]             raddr,
  output logic [mca_pkg::COST_W-1:0] rdata
);
  import mca_pkg::*;

  logic [COST_W-1:0] mem [MAX_DIM*MAX_DIM];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mca_solver.sv
module mca_solver #(
  parameter int MAX_DIM = 16,
  localparam int SAW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mca_pkg::mca_start_t        start,
  output logic                       busy,
  output logic                       res_valid,
  output mca_pkg::mca_res_t          res,
  input  logic                       res_ready,
  output logic [SAW-1:0]             st_raddr,
  input  logic [mca_pkg::COST_W-1:0] st_rdata
);
  import mca_pkg::*;

  localparam int NC = MAX_DIM + 1;
  localparam int IW = $clog2(MAX_DIM + 1);
  localparam int JW = $clog2(MAX_DIM + 2);
  localparam int XW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW = 20 + $clog2(MAX_DIM + 1);
  localparam logic signed [PW-1:0] SLACK_MAX = {1'b0, {(PW-1){1'b1}}};

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_INIT  = 11'b00000000010,
    S_ROW   = 11'b00000000100,
    S_LOADU = 11'b00000001000,
    S_SCAN  = 11'b00000010000,
    S_CHK   = 11'b00000100000,
    S_UPD   = 11'b00001000000,
    S_AUG   = 11'b00010000000,
    S_MAP   = 11'b00100000000,
    S_QUAL  = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } mca_state_t;

  mca_state_t state_r, state_nxt;

  logic [IW-1:0]     nr_r, nc_r, rows_r, cols_r, i_r, j0_r, j1_r, i0_r, sj_r;
  logic [JW-1:0]     j_r, guard_r, t_r;
  logic              trans_r, sv_r, qv_r;
  logic [COST_W-1:0] thr_r;
  logic [XW-1:0]     qt_r;
  logic signed [PW-1:0] ui0_r, delta_r;

  logic signed [PW-1:0] u_r     [NC];
  logic signed [PW-1:0] v_r     [NC];
  logic signed [PW-1:0] slack_r [NC];
  logic [IW-1:0]        owner_r [NC];
  logic [IW-1:0]        back_r  [NC];
  logic [NC-1:0]        used_r;
  logic [XW-1:0]        det_r   [MAX_DIM];
  logic [COST_W-1:0]    rc_r    [MAX_DIM];
  logic [MAX_DIM-1:0]   dv_r, qual_r;

  logic [IW-1:0]     nr_w, nc_w, own_addr, own_rd, jx, ar, ac, trk, det, j1w, tx;
  logic signed [PW-1:0] u_rd, cur, sl_old, sl_new;
  logic              better, take;
  logic [IW-1:0]     sr, sc;
  logic [JW-1:0]     cols_x, nr_x, guard_inc;
  logic [MAX_DIM-1:0] above;

  // matrix size from the last entry, saturated at the store size
  assign nr_w = (32'(start.last_row) + 1 > MAX_DIM) ? IW'(MAX_DIM) : IW'(32'(start.last_row) + 1);
  assign nc_w = (32'(start.last_col) + 1 > MAX_DIM) ? IW'(MAX_DIM) : IW'(32'(start.last_col) + 1);

  assign cols_x    = JW'(cols_r);
  assign nr_x      = JW'(nr_r);
  assign guard_inc = guard_r + 1'b1;
  assign jx        = j_r[IW-1:0];
  assign j1w       = back_r[j0_r];
  assign tx        = t_r[IW-1:0];

  // shared read port of the owner table and row potentials
  always_comb begin
    unique case (state_r)
      S_LOADU: own_addr = j0_r;
      S_AUG:   own_addr = j1w;
      default: own_addr = jx;
    endcase
  end
  assign own_rd = owner_r[own_addr];
  assign u_rd   = u_r[own_rd];

  // reduced cost of the column in the scan stage
  assign sl_old = slack_r[sj_r];
  assign cur    = $signed({{(PW-COST_W){1'b0}}, st_rdata}) - ui0_r - v_r[sj_r];
  assign better = cur < sl_old;
  assign sl_new = better ? cur : sl_old;
  assign take   = !used_r[sj_r] && (sl_new < delta_r);

  // cost store address: scan reads the solved orientation, qualify the original
  assign sr = i0_r - 1'b1;
  assign sc = jx - 1'b1;
  always_comb begin
    if (state_r == S_QUAL) begin
      st_raddr = SAW'(32'(t_r[XW-1:0]) * MAX_DIM + 32'(det_r[t_r[XW-1:0]]));
    end else if (trans_r) begin
      st_raddr = SAW'(32'(sc) * MAX_DIM + 32'(sr));
    end else begin
      st_raddr = SAW'(32'(sr) * MAX_DIM + 32'(sc));
    end
  end

  // column to track mapping
  assign ar  = own_rd - 1'b1;
  assign ac  = jx - 1'b1;
  assign trk = trans_r ? ac : ar;
  assign det = trans_r ? ar : ac;

  // emit: any qualifying pair after the current row
  assign above = (qual_r >> t_r) >> 1;

  always_comb begin
    res_valid    = 1'b0;
    res.row      = '0;
    res.col      = '0;
    res.cost     = '0;
    res.is_match = 1'b0;
    res.last     = 1'b1;
    if (state_r == S_EMIT) begin
      if (qual_r == '0) begin
        res_valid = 1'b1;
      end else if (qual_r[tx[XW-1:0]]) begin
        res_valid    = 1'b1;
        res.row      = IDX_W'(tx);
        res.col      = IDX_W'(det_r[tx[XW-1:0]]);
        res.cost     = rc_r[tx[XW-1:0]];
        res.is_match = 1'b1;
        res.last     = (above == '0);
      end
    end
  end

  assign busy = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start.go) state_nxt = S_INIT;
      S_INIT:  state_nxt = S_ROW;
      S_ROW:   state_nxt = S_LOADU;
      S_LOADU: state_nxt = (own_rd == '0 || guard_r > cols_x) ? S_AUG : S_SCAN;
      S_SCAN:  if (sv_r && sj_r == cols_r) state_nxt = S_CHK;
      S_CHK:   state_nxt = (j1_r == '0) ? S_AUG : S_UPD;
      S_UPD:   if (j_r == cols_x) state_nxt = S_LOADU;
      S_AUG: begin
        if (!(j1w != '0 && guard_inc <= cols_x)) begin
          state_nxt = (i_r == rows_r) ? S_MAP : S_ROW;
        end
      end
      S_MAP:   if (j_r == cols_x) state_nxt = S_QUAL;
      S_QUAL:  if (qv_r && JW'(qt_r) == nr_x - 1'b1) state_nxt = S_EMIT;
      S_EMIT: begin
        if (qual_r == '0) begin
          if (res_ready) state_nxt = S_IDLE;
        end else if (qual_r[tx[XW-1:0]] && res_ready && above == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sv_r    <= 1'b0;
      qv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sv_r    <= (state_r == S_SCAN) && (j_r <= cols_x);
      qv_r    <= (state_r == S_QUAL) && (t_r < nr_x);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start.go) begin
          nr_r    <= nr_w;
          nc_r    <= nc_w;
          trans_r <= nr_w > nc_w;
          rows_r  <= (nr_w > nc_w) ? nc_w : nr_w;
          cols_r  <= (nr_w > nc_w) ? nr_w : nc_w;
          thr_r   <= start.thr;
        end
      end
      S_INIT: begin
        for (int k = 0; k < NC; k++) begin
          u_r[k]     <= '0;
          v_r[k]     <= '0;
          owner_r[k] <= '0;
          back_r[k]  <= '0;
        end
        dv_r <= '0;
        i_r  <= IW'(1);
      end
      // start of a row: fresh search
      S_ROW: begin
        owner_r[0] <= i_r;
        used_r     <= '0;
        for (int k = 0; k < NC; k++) begin
          slack_r[k] <= SLACK_MAX;
        end
        j0_r    <= '0;
        guard_r <= '0;
      end
      S_LOADU: begin
        if (own_rd == '0 || guard_r > cols_x) begin
          guard_r <= '0;
        end else begin
          i0_r         <= own_rd;
          ui0_r        <= u_rd;
          used_r[j0_r] <= 1'b1;
          delta_r      <= SLACK_MAX;
          j1_r         <= '0;
          j_r          <= JW'(1);
        end
      end
      // one column per cycle behind the store read
      S_SCAN: begin
        if (j_r <= cols_x) begin
          sj_r <= jx;
          j_r  <= j_r + 1'b1;
        end
        if (sv_r && !used_r[sj_r]) begin
          if (better) begin
            slack_r[sj_r] <= cur;
            back_r[sj_r]  <= j0_r;
          end
          if (take) begin
            delta_r <= sl_new;
            j1_r    <= sj_r;
          end
        end
      end
      S_CHK: begin
        guard_r <= (j1_r == '0) ? '0 : guard_r;
        j_r     <= '0;
      end
      // potential update, one column per cycle
      S_UPD: begin
        if (used_r[jx]) begin
          u_r[own_rd] <= u_rd + delta_r;
          v_r[jx]     <= v_r[jx] - delta_r;
        end else begin
          slack_r[jx] <= slack_r[jx] - delta_r;
        end
        if (j_r == cols_x) begin
          j0_r    <= j1_r;
          guard_r <= guard_inc;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      // walk back links and flip the path
      S_AUG: begin
        owner_r[j0_r] <= own_rd;
        j0_r          <= j1w;
        guard_r       <= guard_inc;
        if (!(j1w != '0 && guard_inc <= cols_x)) begin
          i_r <= i_r + 1'b1;
          j_r <= JW'(1);
        end
      end
      S_MAP: begin
        if (own_rd != '0 && trk < nr_r && det < nc_r) begin
          det_r[trk[XW-1:0]] <= det[XW-1:0];
          dv_r[trk[XW-1:0]]  <= 1'b1;
        end
        if (j_r == cols_x) begin
          t_r    <= '0;
          qual_r <= '0;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      // cost check per track behind the store read
      S_QUAL: begin
        if (t_r < nr_x) begin
          qt_r <= t_r[XW-1:0];
          t_r  <= t_r + 1'b1;
        end
        if (qv_r) begin
          qual_r[qt_r] <= dv_r[qt_r] && (st_rdata != COST_IMPOSSIBLE) && (st_rdata <= thr_r);
          rc_r[qt_r]   <= st_rdata;
          if (JW'(qt_r) == nr_x - 1'b1) begin
            t_r <= '0;
          end
        end
      end
      S_EMIT: begin
        if (qual_r != '0 && (!qual_r[tx[XW-1:0]] || res_ready)) begin
          t_r <= t_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/min_cost_assignment.sv
// min_cost_assignment: rectangular minimum-cost assignment of tracks (rows)
// to detections (columns).
// in_ch takes one cost entry per request in row-major order; the request with
// last_entry set ends the matrix, its indices give the size and its
// cost_limit the greatest accepted cost. Entries load at one per cycle.
// After the last entry in_ch.ready drops while the solver runs. The solver is
// one shared subtract/compare unit under a sequencer: each augmenting step
// is a column scan behind the cost memory read port, then a potential update
// over the columns; a row takes up to rows steps, and a solve ends with the
// mapping of columns to tracks and the cost check.
// out_ch then gives each accepted pair in ascending row order, last_result on
// the final one, or one empty terminator when no pair passes the threshold.
// A result waits in an output register; a stalled receiver holds the
// sequencer, and the next matrix may start loading while a result waits.
// Reset clears the control state; cost memory contents stay undefined until
// written.
module min_cost_assignment #(
  parameter int MAX_DIM = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mca_in_if.sink      in_ch,
  mca_out_if.source   out_ch
);
  import mca_pkg::*;

  localparam int SAW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  logic              busy, res_valid, res_ready, accept, st_we;
  mca_res_t          res, out_r;
  mca_start_t        start;
  logic              out_valid_r;
  logic [SAW-1:0]    st_waddr, st_raddr;
  logic [COST_W-1:0] st_rdata;

  // input request handling
  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign st_we       = accept && (32'(in_ch.row_index) < MAX_DIM) &&
                       (32'(in_ch.col_index) < MAX_DIM);
  assign st_waddr    = SAW'(32'(in_ch.row_index) * MAX_DIM + 32'(in_ch.col_index));

  assign start.go       = accept && in_ch.last_entry;
  assign start.last_row = in_ch.row_index;
  assign start.last_col = in_ch.col_index;
  assign start.thr      = in_ch.cost_limit;

  mca_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (in_ch.cost),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mca_solver #(.MAX_DIM(MAX_DIM)) u_solver (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.match_row   = out_r.row;
  assign out_ch.match_col   = out_r.col;
  assign out_ch.match_cost  = out_r.cost;
  assign out_ch.is_match    = out_r.is_match;
  assign out_ch.last_result = out_r.last;

endmodule

// File: test/min_cost_assignment_tb.sv
module min_cost_assignment_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mca_pkg::*;

  localparam int DIM = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 64;
  localparam longint SLACK_TOP = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [COST_W-1:0] cost;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [COST_W-1:0] thr;
    logic              last;
  } entry_t;

  typedef struct {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [COST_W-1:0] cost;
    logic              is_match;
    logic              last;
  } pair_t;

  typedef struct {
    entry_t e;
    bit     typed;
    pair_t  want;
  } step_t;

  logic clk;
  logic rst_n;
  mca_in_if  in_ch();
  mca_out_if out_ch();

  min_cost_assignment u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [COST_W-1:0] cost_mem [DIM*DIM];
  longint row_pot [DIM+1];
  longint col_pot [DIM+1];
  longint slack [DIM+1];
  int owner [DIM+1];
  int link [DIM+1];
  bit used [DIM+1];
  bit flipped;

  pair_t pending_pairs [$];
  int errors = 0;
  int pairs_seen = 0;
  int matrices = 0;
  int cycles = 0;
  bit calm = 0;

  function automatic longint cell_at(int r, int c);
    int idx;
    idx = flipped ? c * DIM + r : r * DIM + c;
    return longint'(cost_mem[idx]);
  endfunction

  // shortest augmenting path assignment, lowest column wins ties
  function automatic void assign_solve(int nr, int nc);
    int rows, cols, i, j, j0, j1, i0, guard;
    longint delta, cur;
    flipped = nr > nc;
    rows = flipped ? nc : nr;
    cols = flipped ? nr : nc;
    for (j = 0; j <= DIM; j++) begin
      row_pot[j] = 0; col_pot[j] = 0; owner[j] = 0; link[j] = 0;
    end
    for (i = 1; i <= rows; i++) begin
      j0 = 0;
      owner[0] = i;
      for (j = 0; j <= DIM; j++) begin
        slack[j] = SLACK_TOP; used[j] = 0;
      end
      guard = 0;
      do begin
        i0 = owner[j0];
        j1 = 0;
        delta = SLACK_TOP;
        used[j0] = 1;
        for (j = 1; j <= cols; j++) begin
          if (!used[j]) begin
            cur = cell_at(i0 - 1, j - 1) - row_pot[i0] - col_pot[j];
            if (cur < slack[j]) begin
              slack[j] = cur; link[j] = j0;
            end
            if (slack[j] < delta) begin
              delta = slack[j]; j1 = j;
            end
          end
        end
        if (j1 == 0) break;
        for (j = 0; j <= cols; j++) begin
          if (used[j]) begin
            row_pot[owner[j]] += delta;
            col_pot[j] -= delta;
          end else begin
            slack[j] -= delta;
          end
        end
        j0 = j1;
        guard++;
      end while (owner[j0] != 0 && guard <= cols);
      guard = 0;
      do begin
        j1 = link[j0];
        owner[j0] = owner[j1];
        j0 = j1;
        guard++;
      end while (j0 != 0 && guard <= cols);
    end
  endfunction

  // store one entry and, on the last one, queue the expected pairs when record is set
  function automatic void predict_pairs(entry_t e, bit record);
    int nr, nc, col, ar, ac, trk, det, t, n;
    int det_of [DIM];
    logic [COST_W-1:0] pc;
    pair_t p;
    cost_mem[e.row * DIM + e.col] = e.cost;
    if (!e.last) return;
    nr = e.row + 1;
    nc = e.col + 1;
    assign_solve(nr, nc);
    for (t = 0; t < DIM; t++) det_of[t] = -1;
    for (col = 1; col <= (flipped ? nr : nc); col++) begin
      if (owner[col] != 0) begin
        ar = owner[col] - 1;
        ac = col - 1;
        trk = flipped ? ac : ar;
        det = flipped ? ar : ac;
        if (trk < nr && det < nc) det_of[trk] = det;
      end
    end
    n = 0;
    for (t = 0; t < nr; t++) begin
      if (det_of[t] >= 0) begin
        pc = cost_mem[t * DIM + det_of[t]];
        if (pc != COST_IMPOSSIBLE && pc <= e.thr) begin
          p.row = IDX_W'(t); p.col = IDX_W'(det_of[t]); p.cost = pc;
          p.is_match = 1; p.last = 0;
          if (record) pending_pairs.insert(pending_pairs.size(), p);
          n++;
        end
      end
    end
    if (!record) return;
    if (n == 0) begin
      p.row = 0; p.col = 0; p.cost = 0; p.is_match = 0; p.last = 1;
      pending_pairs.insert(pending_pairs.size(), p);
    end else begin
      pending_pairs[pending_pairs.size()-1].last = 1;
    end
  endfunction

  // drive one request and wait for it to be taken
  task automatic send_entry(step_t s);
    if (!calm) begin
      while ($urandom_range(0, 99) < 25) begin
        in_ch.valid = 0;
        @(negedge clk);
      end
    end
    in_ch.cost = s.e.cost;
    in_ch.row_index = s.e.row;
    in_ch.col_index = s.e.col;
    in_ch.cost_limit = s.e.thr;
    in_ch.last_entry = s.e.last;
    in_ch.valid = 1;
    do @(posedge clk); while (!in_ch.ready);
    predict_pairs(s.e, !s.typed);
    if (s.typed) pending_pairs.insert(pending_pairs.size(), s.want);
    if (s.e.last) matrices++;
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  // full row-major matrix with random content
  task automatic send_matrix(int nr, int nc);
    int r, c, mode;
    step_t s;
    logic [COST_W-1:0] thr;
    mode = $urandom_range(0, 3);
    case ($urandom_range(0, 4))
      0: thr = 0;
      1: thr = COST_IMPOSSIBLE;
      2: thr = 16'd32768;
      default: thr = COST_W'($urandom);
    endcase
    s.typed = 0;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        case ($urandom_range(0, 9))
          0: s.e.cost = COST_IMPOSSIBLE;
          1: s.e.cost = 0;
          2: s.e.cost = COST_IMPOSSIBLE - 1;
          3, 4: s.e.cost = COST_W'($urandom_range(0, 7));
          default: s.e.cost = (mode == 0) ? COST_W'($urandom_range(0, 40000)) :
                                            COST_W'($urandom);
        endcase
        s.e.row = IDX_W'(r);
        s.e.col = IDX_W'(c);
        s.e.thr = COST_W'($urandom);
        s.e.last = (r == nr - 1) && (c == nc - 1);
        if (s.e.last) s.e.thr = thr;
        send_entry(s);
      end
    end
  endtask

  function automatic step_t mk(int cost, int r, int c, int thr, bit last, bit typed = 0,
                               int wr = 0, int wc = 0, int wcost = 0, bit wm = 0);
    step_t s;
    s.e.cost = COST_W'(cost); s.e.row = IDX_W'(r); s.e.col = IDX_W'(c);
    s.e.thr = COST_W'(thr); s.e.last = last;
    s.typed = typed;
    s.want.row = IDX_W'(wr); s.want.col = IDX_W'(wc); s.want.cost = COST_W'(wcost);
    s.want.is_match = wm; s.want.last = 1;
    return s;
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 0;
    end else begin
      out_ch.ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end
  end

  // result checker
  always @(posedge clk) begin
    pair_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      pairs_seen++;
      if (pending_pairs.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result row=%0d col=%0d cost=%0d match=%0b last=%0b",
                   out_ch.match_row, out_ch.match_col, out_ch.match_cost,
                   out_ch.is_match, out_ch.last_result);
      end else begin
        w = pending_pairs.pop_front();
        if (out_ch.match_row !== w.row || out_ch.match_col !== w.col ||
            out_ch.match_cost !== w.cost || out_ch.is_match !== w.is_match ||
            out_ch.last_result !== w.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %0d %0d %0d %0b %0b got %0d %0d %0d %0b %0b",
                     w.row, w.col, w.cost, w.is_match, w.last,
                     out_ch.match_row, out_ch.match_col, out_ch.match_cost,
                     out_ch.is_match, out_ch.last_result);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[min_cost_assignment] ERROR");
      $finish;
    end
  end

  initial begin
    step_t dir_tab [$];
    int k, nr, nc;
    clk = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.cost = 0;
    in_ch.row_index = 0;
    in_ch.col_index = 0;
    in_ch.cost_limit = 0;
    in_ch.last_entry = 0;
    out_ch.ready = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // single entries with known outcomes, then small ties and transposed shapes
    dir_tab.insert(dir_tab.size(), mk(0, 0, 0, 0, 1, 1, 0, 0, 0, 1));
    dir_tab.insert(dir_tab.size(), mk(65535, 0, 0, 65535, 1, 1));
    dir_tab.insert(dir_tab.size(), mk(65534, 0, 0, 65535, 1, 1, 0, 0, 65534, 1));
    dir_tab.insert(dir_tab.size(), mk(32768, 0, 0, 32767, 1, 1));
    dir_tab.insert(dir_tab.size(), mk(32768, 0, 0, 32768, 1, 1, 0, 0, 32768, 1));
    dir_tab.insert(dir_tab.size(), mk(7, 0, 0, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(7, 0, 1, 65535, 1));
    dir_tab.insert(dir_tab.size(), mk(9, 0, 0, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(2, 1, 0, 65535, 1));
    dir_tab.insert(dir_tab.size(), mk(65535, 0, 0, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(1, 0, 1, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(1, 1, 0, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(65535, 1, 1, 1, 1));
    dir_tab.insert(dir_tab.size(), mk(5, 0, 0, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(5, 0, 1, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(5, 0, 2, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(5, 1, 0, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(5, 1, 1, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(4, 1, 2, 4, 1));
    dir_tab.insert(dir_tab.size(), mk(40000, 0, 0, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(100, 1, 0, 0, 0));
    dir_tab.insert(dir_tab.size(), mk(65535, 2, 0, 32768, 1));
    for (k = 0; k < dir_tab.size(); k++) send_entry(dir_tab[k]);

    // longest row and column once each, then random small matrices
    send_matrix(16, 1);
    send_matrix(1, 16);
    for (k = 0; k < 8; k++) begin
      if (k == 2) begin
        // let everything drain before the next matrix
        while (pending_pairs.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
      end
      calm = (k >= 3 && k < 7);
      nr = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
      nc = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
      // a stray entry that the full matrix then overwrites
      if ($urandom_range(0, 4) == 0)
        send_entry(mk($urandom, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                      $urandom, 0));
      send_matrix(nr, nc);
    end
    calm = 0;

    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d matrices from 1x1 up to 16 rows or 16 columns", matrices);
    $display("%0d results checked, %0d mismatches", pairs_seen, errors);
    if (errors == 0) begin
      $display("[min_cost_assignment] OK");
    end else begin
      $display("[min_cost_assignment] ERROR");
    end
    $finish;
  end

endmodule
